// ----- sv/fsnp_pkg.sv -----
// Package for the format string number printer: constants, microcode types and control store.
package fsnp_pkg;

  // Conversion digit limits and the digit buffer that holds one number.
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned DIG_DEPTH  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int unsigned DIG_CNT_W  = $clog2(DIG_DEPTH + 1);
  localparam int unsigned DIG_IDX_W  = (DIG_DEPTH > 1) ? $clog2(DIG_DEPTH) : 1;

  // Divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for every 32-bit v.
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;
  localparam int unsigned DEC_Q_W       = 64 - RECIP10_SHIFT;

  // Characters.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ALPHA   = 8'h41 - 8'd10;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOW_D   = 8'h64;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_LOW_C   = 8'h63;
  localparam logic [7:0] CH_LOW_S   = 8'h73;

  typedef enum logic [1:0] {
    CMD_FMT  = 2'd0,
    CMD_ARG  = 2'd1,
    CMD_STR  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Program steps.
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_EMIT_BYTE = 4'd1,
    ST_DONE      = 4'd2,
    ST_HEX_0     = 4'd3,
    ST_HEX_X     = 4'd4,
    ST_HEX_DIG   = 4'd5,
    ST_DEC_MUL   = 4'd6,
    ST_DEC_REM   = 4'd7,
    ST_DIG_OUT   = 4'd8
  } step_e;

  typedef enum logic [2:0] {
    SRC_BYTE,
    SRC_STATUS,
    SRC_ZERO,
    SRC_X,
    SRC_DIGIT
  } src_e;

  typedef enum logic [1:0] {
    LAST_NEVER,
    LAST_ALWAYS,
    LAST_DIGIT
  } last_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_HEX_STEP,
    OP_DEC_MUL,
    OP_DEC_REM,
    OP_POP
  } op_e;

  typedef enum logic [2:0] {
    COND_WAIT_ITEM,
    COND_ALWAYS,
    COND_HEX_END,
    COND_DEC_END,
    COND_LAST_DIGIT
  } cond_e;

  // One control word: jump is taken when the condition holds, else next; the wait step takes the dispatched step.
  typedef struct packed {
    logic  emit;
    src_e  src;
    last_e last;
    op_e   op;
    cond_e cond;
    step_e jump;
    step_e next;
  } ctrl_t;

  function automatic ctrl_t rom_word(step_e step);
    ctrl_t w;
    w = '{emit: 1'b0, src: SRC_BYTE, last: LAST_NEVER, op: OP_LOAD,
          cond: COND_WAIT_ITEM, jump: ST_IDLE, next: ST_IDLE};
    unique case (step)
      ST_IDLE:      w = '{1'b0, SRC_BYTE,   LAST_NEVER,  OP_LOAD,     COND_WAIT_ITEM,
                          ST_IDLE, ST_IDLE};
      ST_EMIT_BYTE: w = '{1'b1, SRC_BYTE,   LAST_ALWAYS, OP_NONE,     COND_ALWAYS,
                          ST_IDLE, ST_IDLE};
      ST_DONE:      w = '{1'b1, SRC_STATUS, LAST_ALWAYS, OP_NONE,     COND_ALWAYS,
                          ST_IDLE, ST_IDLE};
      ST_HEX_0:     w = '{1'b1, SRC_ZERO,   LAST_NEVER,  OP_NONE,     COND_ALWAYS,
                          ST_HEX_X, ST_HEX_X};
      ST_HEX_X:     w = '{1'b1, SRC_X,      LAST_NEVER,  OP_NONE,     COND_ALWAYS,
                          ST_HEX_DIG, ST_HEX_DIG};
      ST_HEX_DIG:   w = '{1'b0, SRC_BYTE,   LAST_NEVER,  OP_HEX_STEP, COND_HEX_END,
                          ST_DIG_OUT, ST_HEX_DIG};
      ST_DEC_MUL:   w = '{1'b0, SRC_BYTE,   LAST_NEVER,  OP_DEC_MUL,  COND_DEC_END,
                          ST_DIG_OUT, ST_DEC_REM};
      ST_DEC_REM:   w = '{1'b0, SRC_BYTE,   LAST_NEVER,  OP_DEC_REM,  COND_ALWAYS,
                          ST_DEC_MUL, ST_DEC_MUL};
      ST_DIG_OUT:   w = '{1'b1, SRC_DIGIT,  LAST_DIGIT,  OP_POP,      COND_LAST_DIGIT,
                          ST_IDLE, ST_DIG_OUT};
      default:      w = '{1'b0, SRC_BYTE,   LAST_NEVER,  OP_LOAD,     COND_WAIT_ITEM,
                          ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

  // ASCII for one digit value; hex letters are uppercase.
  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_ALPHA + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// ----- sv/format_string_number_printer_core.sv -----
// Top level of the format string number printer: a microcoded printf-style interpreter.
//
// The block takes format bytes, argument words and string bytes on a valid/ready input
// channel and sends ASCII characters out on a valid/ready result channel, one result
// per cycle at most. A plain format byte passes through, "%%" gives '%', "%d" prints
// the next argument word in decimal, "%x" prints "0x" and uppercase hex, "%c" prints
// the argument's low byte and "%s" passes string bytes until a zero string byte.
// A zero format byte ends the message with one status result (done_res_o) that carries
// the number of characters sent, and the count restarts. Every result carries the
// destination register in route_o, and last_o marks the final result of an item.
// One item is taken at a time: the input is ready only while the sequencer sits on
// its wait step, and a finished result may still wait in the output register then.
// The control store steps one word per cycle unless a character step waits on a stalled
// output; a zero argument still prints a single '0'. The decimal digits come out of a
// divide-by-ten multiplier that needs two steps per digit (multiply, then remainder),
// and every character leaves through the single output register.
module format_string_number_printer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_byte_i,
  input  logic [31:0] arg_word_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        char_valid_o,
  output logic        route_o,
  output logic        last_o,
  output logic        done_res_o,
  output logic [31:0] total_length_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PCT,
    MODE_ARG_D,
    MODE_ARG_X,
    MODE_ARG_C,
    MODE_STR
  } mode_e;

  localparam logic [fsnp_pkg::DIG_CNT_W-1:0] DEC_LIMIT =
    fsnp_pkg::DIG_CNT_W'(fsnp_pkg::DEC_DIGITS);
  localparam logic [fsnp_pkg::DIG_CNT_W-1:0] HEX_LIMIT =
    fsnp_pkg::DIG_CNT_W'(fsnp_pkg::HEX_DIGITS);

  // Control state
  fsnp_pkg::step_e step_q, step_d;
  mode_e           mode_q, mode_d;
  logic [31:0]     cnt_q, cnt_d;
  logic            dest_q, dest_d;
  logic [fsnp_pkg::DIG_CNT_W-1:0] dig_n_q, dig_n_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        char_valid_q, char_valid_d;
  logic        route_q, route_d;
  logic        last_q, last_d;
  logic        done_q, done_d;
  logic [31:0] total_q, total_d;

  // Datapath
  logic [31:0]                  val_q, val_d;
  logic [fsnp_pkg::DEC_Q_W-1:0] quot_q, quot_d;
  logic [7:0]                   byte_q, byte_d;
  logic [3:0]                   dig_q [fsnp_pkg::DIG_DEPTH];

  fsnp_pkg::ctrl_t ctrl;
  fsnp_pkg::step_e disp_step;
  mode_e           disp_mode;
  logic            in_fire;
  logic            out_free;
  logic            emit_fire;
  logic            advance;
  logic            hex_end;
  logic            dec_end;
  logic            digit_last;
  logic            push;
  logic [3:0]      push_digit;
  logic [63:0]     prod;
  logic [31:0]     quot_x10;
  logic [31:0]     rem;
  logic [fsnp_pkg::DIG_IDX_W-1:0] push_idx;
  logic [fsnp_pkg::DIG_IDX_W-1:0] pop_idx;
  logic [fsnp_pkg::DIG_CNT_W-1:0] pop_cnt;
  logic [7:0]      digit_ch;

  assign ctrl = fsnp_pkg::rom_word(step_q);

  // Handshakes: take an item only on the wait step; the output register frees when its
  // item is taken in the same cycle.
  assign in_ready_o = (ctrl.cond == fsnp_pkg::COND_WAIT_ITEM);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign emit_fire  = ctrl.emit & out_free;
  assign advance    = ~ctrl.emit | out_free;

  // Digit extraction
  assign prod       = val_q * fsnp_pkg::RECIP10;
  assign quot_x10   = {quot_q, 3'b000} + {2'b00, quot_q, 1'b0};
  assign rem        = val_q - quot_x10;
  assign hex_end    = (val_q == 32'd0) || (dig_n_q == HEX_LIMIT);
  assign dec_end    = (val_q == 32'd0) || (dig_n_q == DEC_LIMIT);
  assign digit_last = (dig_n_q <= fsnp_pkg::DIG_CNT_W'(1));
  assign push_idx   = dig_n_q[fsnp_pkg::DIG_IDX_W-1:0];
  assign pop_cnt    = dig_n_q - fsnp_pkg::DIG_CNT_W'(1);
  assign pop_idx    = pop_cnt[fsnp_pkg::DIG_IDX_W-1:0];
  assign digit_ch   = (dig_n_q == '0) ? fsnp_pkg::CH_ZERO
                                      : fsnp_pkg::digit_char(dig_q[pop_idx]);

  // Dispatch decode: pick the entry step of the program and the next parse mode.
  always_comb begin
    disp_step = fsnp_pkg::ST_IDLE;
    disp_mode = mode_q;
    unique case (fsnp_pkg::cmd_e'(cmd_i))
      fsnp_pkg::CMD_FMT: begin
        disp_mode = MODE_IDLE;
        if (char_byte_i == fsnp_pkg::CH_NUL) begin
          disp_step = fsnp_pkg::ST_DONE;
        end else if (mode_q == MODE_PCT) begin
          // Conversion letter; unknown letters drop silently.
          if (char_byte_i == fsnp_pkg::CH_PERCENT) begin
            disp_step = fsnp_pkg::ST_EMIT_BYTE;
          end else if (char_byte_i == fsnp_pkg::CH_LOW_D) begin
            disp_mode = MODE_ARG_D;
          end else if (char_byte_i == fsnp_pkg::CH_LOW_X) begin
            disp_mode = MODE_ARG_X;
          end else if (char_byte_i == fsnp_pkg::CH_LOW_C) begin
            disp_mode = MODE_ARG_C;
          end else if (char_byte_i == fsnp_pkg::CH_LOW_S) begin
            disp_mode = MODE_STR;
          end
        end else if (char_byte_i == fsnp_pkg::CH_PERCENT) begin
          disp_mode = MODE_PCT;
        end else begin
          // Plain text; a pending conversion is abandoned.
          disp_step = fsnp_pkg::ST_EMIT_BYTE;
        end
      end
      fsnp_pkg::CMD_ARG: begin
        // Arguments that nothing waits for are ignored.
        if (mode_q == MODE_ARG_D) begin
          disp_mode = MODE_IDLE;
          disp_step = fsnp_pkg::ST_DEC_MUL;
        end else if (mode_q == MODE_ARG_X) begin
          disp_mode = MODE_IDLE;
          disp_step = fsnp_pkg::ST_HEX_0;
        end else if (mode_q == MODE_ARG_C) begin
          disp_mode = MODE_IDLE;
          disp_step = fsnp_pkg::ST_EMIT_BYTE;
        end
      end
      fsnp_pkg::CMD_STR: begin
        if (mode_q == MODE_STR) begin
          if (char_byte_i == fsnp_pkg::CH_NUL) begin
            disp_mode = MODE_IDLE;
          end else begin
            disp_step = fsnp_pkg::ST_EMIT_BYTE;
          end
        end
      end
      default: begin
        disp_step = fsnp_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer: step counter with conditional jumps.
  always_comb begin
    step_d = step_q;
    unique case (ctrl.cond)
      fsnp_pkg::COND_WAIT_ITEM: begin
        step_d = in_fire ? disp_step : fsnp_pkg::ST_IDLE;
      end
      fsnp_pkg::COND_ALWAYS: begin
        if (advance) begin
          step_d = ctrl.jump;
        end
      end
      fsnp_pkg::COND_HEX_END: begin
        step_d = hex_end ? ctrl.jump : ctrl.next;
      end
      fsnp_pkg::COND_DEC_END: begin
        step_d = dec_end ? ctrl.jump : ctrl.next;
      end
      fsnp_pkg::COND_LAST_DIGIT: begin
        if (advance) begin
          step_d = digit_last ? ctrl.jump : ctrl.next;
        end
      end
      default: begin
        step_d = fsnp_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: operand load, digit extraction and digit count.
  always_comb begin
    mode_d     = mode_q;
    val_d      = val_q;
    quot_d     = quot_q;
    byte_d     = byte_q;
    dig_n_d    = dig_n_q;
    push       = 1'b0;
    push_digit = val_q[3:0];
    case (ctrl.op)
      fsnp_pkg::OP_LOAD: begin
        if (in_fire) begin
          mode_d  = disp_mode;
          val_d   = arg_word_i;
          byte_d  = (fsnp_pkg::cmd_e'(cmd_i) == fsnp_pkg::CMD_ARG) ? arg_word_i[7:0]
                                                                    : char_byte_i;
          dig_n_d = '0;
        end
      end
      fsnp_pkg::OP_HEX_STEP: begin
        if (!hex_end) begin
          push    = 1'b1;
          val_d   = {4'b0000, val_q[31:4]};
          dig_n_d = dig_n_q + fsnp_pkg::DIG_CNT_W'(1);
        end
      end
      fsnp_pkg::OP_DEC_MUL: begin
        if (!dec_end) begin
          quot_d = prod[63:fsnp_pkg::RECIP10_SHIFT];
        end
      end
      fsnp_pkg::OP_DEC_REM: begin
        push       = 1'b1;
        push_digit = rem[3:0];
        val_d      = 32'(quot_q);
        dig_n_d    = dig_n_q + fsnp_pkg::DIG_CNT_W'(1);
      end
      fsnp_pkg::OP_POP: begin
        if (emit_fire && dig_n_q != '0) begin
          dig_n_d = pop_cnt;
        end
      end
      default: begin
        dig_n_d = dig_n_q;
      end
    endcase
  end

  // Result assembly into the output register; count characters, clear on status.
  always_comb begin
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_char_d   = out_char_q;
    char_valid_d = char_valid_q;
    route_d      = route_q;
    last_d       = last_q;
    done_d       = done_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    dest_d       = cfg_we_i ? cfg_wdata_i : dest_q;
    if (emit_fire) begin
      out_valid_d  = 1'b1;
      route_d      = dest_q;
      char_valid_d = 1'b1;
      done_d       = 1'b0;
      total_d      = 32'd0;
      cnt_d        = cnt_q + 32'd1;
      case (ctrl.src)
        fsnp_pkg::SRC_BYTE:  out_char_d = byte_q;
        fsnp_pkg::SRC_ZERO:  out_char_d = fsnp_pkg::CH_ZERO;
        fsnp_pkg::SRC_X:     out_char_d = fsnp_pkg::CH_LOW_X;
        fsnp_pkg::SRC_DIGIT: out_char_d = digit_ch;
        default: begin
          out_char_d   = fsnp_pkg::CH_NUL;
          char_valid_d = 1'b0;
          done_d       = 1'b1;
          total_d      = cnt_q;
          cnt_d        = 32'd0;
        end
      endcase
      case (ctrl.last)
        fsnp_pkg::LAST_ALWAYS: last_d = 1'b1;
        fsnp_pkg::LAST_DIGIT:  last_d = digit_last;
        default:               last_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= fsnp_pkg::ST_IDLE;
      mode_q       <= MODE_IDLE;
      cnt_q        <= 32'd0;
      dest_q       <= 1'b0;
      dig_n_q      <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= 8'd0;
      char_valid_q <= 1'b0;
      route_q      <= 1'b0;
      last_q       <= 1'b0;
      done_q       <= 1'b0;
      total_q      <= 32'd0;
    end else begin
      step_q       <= step_d;
      mode_q       <= mode_d;
      cnt_q        <= cnt_d;
      dest_q       <= dest_d;
      dig_n_q      <= dig_n_d;
      out_valid_q  <= out_valid_d;
      out_char_q   <= out_char_d;
      char_valid_q <= char_valid_d;
      route_q      <= route_d;
      last_q       <= last_d;
      done_q       <= done_d;
      total_q      <= total_d;
    end
  end

  // Operands and digit buffer carry no reset.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quot_q <= quot_d;
    byte_q <= byte_d;
    if (push) begin
      dig_q[push_idx] <= push_digit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign char_valid_o   = char_valid_q;
  assign route_o        = route_q;
  assign last_o         = last_q;
  assign done_res_o     = done_q;
  assign total_length_o = total_q;

  // A status result is always the final one of its item and carries no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (last_o && !char_valid_o && out_char_o == 8'd0))
    else $error("status result malformed");

  // Character results report no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_valid_o) |-> (total_length_o == 32'd0 && !done_res_o))
    else $error("character result carries status");

  // The digit buffer never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_n_q <= fsnp_pkg::DIG_CNT_W'(fsnp_pkg::DIG_DEPTH))
    else $error("digit buffer overflow");

  // The remainder step only follows a multiply step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == fsnp_pkg::ST_DEC_REM) |-> ($past(step_q) == fsnp_pkg::ST_DEC_MUL))
    else $error("remainder step out of sequence");

  // A decimal digit is always below ten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == fsnp_pkg::ST_DEC_REM) |-> (rem < 32'd10))
    else $error("decimal remainder out of range");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the format string number printer core.
`timescale 1ns / 1ps

module tb_top;

  // Run shape: random items to feed, settle time after the last result, watchdog.
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  // Interpreter state as the predictor tracks it.
  typedef enum logic [2:0] {
    PM_PLAIN,
    PM_PERCENT,
    PM_WANT_DEC,
    PM_WANT_HEX,
    PM_WANT_CHR,
    PM_IN_STR
  } parse_e;

  // One printed result, laid out as the output ports.
  typedef struct packed {
    logic [7:0]  ch;
    logic        chv;
    logic        route;
    logic        last;
    logic        done;
    logic [31:0] total;
  } printed_t;

  // Predict the characters each accepted item prints and check them in order.
  class print_scoreboard;
    parse_e      mode;
    logic [31:0] sent_count;
    logic        dest;
    printed_t    due_q[$];
    printed_t    fresh_q[$];
    int          errors;
    int          checked;

    function new();
      mode       = PM_PLAIN;
      sent_count = '0;
      dest       = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void emit_char(logic [7:0] c);
      printed_t r;
      r = '{ch: c, chv: 1'b1, route: dest, last: 1'b0, done: 1'b0, total: '0};
      fresh_q.push_back(r);
      sent_count++;
    endfunction

    // End of message: report the count, then start over in plain text.
    function void emit_status();
      printed_t r;
      r = '{ch: fsnp_pkg::CH_NUL, chv: 1'b0, route: dest, last: 1'b0, done: 1'b1,
            total: sent_count};
      fresh_q.push_back(r);
      sent_count = '0;
      mode       = PM_PLAIN;
    endfunction

    // Print most significant digit first; a zero value still prints one '0'.
    function void emit_number(logic [31:0] v, int unsigned radix, int unsigned max_digits);
      logic [3:0]  digs[20];
      logic [3:0]  d;
      int unsigned n;
      n = 0;
      while (n < max_digits && n < 20 && v != 0) begin
        digs[n] = 4'(v % radix);
        v       = v / radix;
        n++;
      end
      if (n == 0) begin
        emit_char(fsnp_pkg::CH_ZERO);
      end
      while (n > 0) begin
        n--;
        d = digs[n];
        if (d <= 4'd9) begin
          emit_char(fsnp_pkg::CH_ZERO + {4'b0, d});
        end else begin
          emit_char(fsnp_pkg::CH_ALPHA + {4'b0, d});
        end
      end
    endfunction

    function void take_format(logic [7:0] b);
      if (mode != PM_PERCENT) begin
        // Plain text, or a pending conversion that this byte abandons.
        mode = PM_PLAIN;
        if (b == fsnp_pkg::CH_NUL) begin
          emit_status();
        end else if (b == fsnp_pkg::CH_PERCENT) begin
          mode = PM_PERCENT;
        end else begin
          emit_char(b);
        end
      end else begin
        mode = PM_PLAIN;
        if (b == fsnp_pkg::CH_NUL) begin
          emit_status();
        end else if (b == fsnp_pkg::CH_PERCENT) begin
          emit_char(fsnp_pkg::CH_PERCENT);
        end else if (b == fsnp_pkg::CH_LOW_D) begin
          mode = PM_WANT_DEC;
        end else if (b == fsnp_pkg::CH_LOW_X) begin
          mode = PM_WANT_HEX;
        end else if (b == fsnp_pkg::CH_LOW_C) begin
          mode = PM_WANT_CHR;
        end else if (b == fsnp_pkg::CH_LOW_S) begin
          mode = PM_IN_STR;
        end
      end
    endfunction

    function void take_arg(logic [31:0] w);
      case (mode)
        PM_WANT_DEC: begin
          emit_number(w, 10, fsnp_pkg::DEC_DIGITS);
          mode = PM_PLAIN;
        end
        PM_WANT_HEX: begin
          emit_char(fsnp_pkg::CH_ZERO);
          emit_char(fsnp_pkg::CH_LOW_X);
          emit_number(w, 16, fsnp_pkg::HEX_DIGITS);
          mode = PM_PLAIN;
        end
        PM_WANT_CHR: begin
          emit_char(w[7:0]);
          mode = PM_PLAIN;
        end
        default: ;
      endcase
    endfunction

    function void note_item(fsnp_pkg::cmd_e cmd, logic [7:0] b, logic [31:0] w);
      printed_t r;
      fresh_q.delete();
      case (cmd)
        fsnp_pkg::CMD_FMT: take_format(b);
        fsnp_pkg::CMD_ARG: take_arg(w);
        fsnp_pkg::CMD_STR: begin
          if (mode == PM_IN_STR) begin
            if (b == fsnp_pkg::CH_NUL) begin
              mode = PM_PLAIN;
            end else begin
              emit_char(b);
            end
          end
        end
        default: ;
      endcase
      // Flag the final result of this item.
      if (fresh_q.size() > 0) begin
        r      = fresh_q.pop_back();
        r.last = 1'b1;
        fresh_q.push_back(r);
      end
      foreach (fresh_q[i]) begin
        due_q.push_back(fresh_q[i]);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void same_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(printed_t got);
      printed_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        $error("result with no item pending: out_char %0h", got.ch);
        return;
      end
      want = due_q.pop_front();
      same_field("out_char", 32'(want.ch), 32'(got.ch));
      same_field("char_valid", 32'(want.chv), 32'(got.chv));
      same_field("route", 32'(want.route), 32'(got.route));
      same_field("last", 32'(want.last), 32'(got.last));
      same_field("done_res", 32'(want.done), 32'(got.done));
      same_field("total_length", want.total, got.total);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [7:0]  char_byte_i;
  logic [31:0] arg_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_char_o;
  logic        char_valid_o;
  logic        route_o;
  logic        last_o;
  logic        done_res_o;
  logic [31:0] total_length_o;

  print_scoreboard sb = new();

  // Both sides idle at random while this is set; clear it for back-to-back stretches.
  bit          idle_on = 1'b1;
  // Cycles the sender waits before offering the next item.
  int unsigned gap_ahead = 0;
  // Items fed that the block does not merely ignore.
  int unsigned fed = 0;

  always #5 clk_i = ~clk_i;

  format_string_number_printer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .char_byte_i    (char_byte_i),
    .arg_word_i     (arg_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .char_valid_o   (char_valid_o),
    .route_o        (route_o),
    .last_o         (last_o),
    .done_res_o     (done_res_o),
    .total_length_o (total_length_o)
  );

  // Offer one item and hold it until accepted. Drop valid at the accepting edge
  // only if the next item waits; otherwise the next call replaces the payload in
  // place so valid never falls and rises within one step.
  task automatic send_item(input fsnp_pkg::cmd_e cmd, input logic [7:0] b,
                           input logic [31:0] w, input bit counted);
    if (gap_ahead > 0) begin
      repeat (gap_ahead) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    char_byte_i <= b;
    arg_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(cmd, b, w);
    if (counted) begin
      fed++;
    end
    gap_ahead = idle_on ? $urandom_range(0, 9) : 0;
    if (gap_ahead > 0) begin
      in_valid_i <= 1'b0;
    end
  endtask

  // Call in the step of the last acceptance: drop valid unless already dropped.
  task automatic stop_sending();
    if (gap_ahead == 0) begin
      in_valid_i <= 1'b0;
    end
    gap_ahead = 0;
  endtask

  // Wait for every expected result, then let an item with no result finish.
  task automatic settle(input int unsigned tail);
    while (sb.pending() != 0) @(posedge clk_i);
    if (tail > 0) begin
      repeat (tail) @(posedge clk_i);
    end
  endtask

  task automatic set_destination(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.dest = v;
  endtask

  function automatic logic [31:0] pick_arg();
    logic [31:0] p;
    int unsigned k;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 255);
      2: return $urandom();
      3: return 32'hFFFF_FFFF;
      4: begin
        // Decimal digit-count boundaries: 10^k and 10^k - 1.
        k = $urandom_range(1, 9);
        repeat (k) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = pick_byte(); while (b == fsnp_pkg::CH_PERCENT);
    return b;
  endfunction

  function automatic logic [7:0] pick_unknown_conv();
    logic [7:0] b;
    do b = pick_byte();
    while (b == fsnp_pkg::CH_PERCENT || b == fsnp_pkg::CH_LOW_D ||
           b == fsnp_pkg::CH_LOW_X || b == fsnp_pkg::CH_LOW_C || b == fsnp_pkg::CH_LOW_S);
    return b;
  endfunction

  function automatic logic [7:0] pick_numeric_conv();
    case ($urandom_range(0, 2))
      0:       return fsnp_pkg::CH_LOW_D;
      1:       return fsnp_pkg::CH_LOW_X;
      default: return fsnp_pkg::CH_LOW_C;
    endcase
  endfunction

  // Extremes of every field, every conversion and each corner case once.
  task automatic run_directed();
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_NUL, '0, 1'b1);      // empty message
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // percent escape
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // decimal zero
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_D, '0, 1'b1);
    send_item(fsnp_pkg::CMD_ARG, 8'hFF, 32'h0, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // ten-digit decimal
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_D, '0, 1'b1);
    send_item(fsnp_pkg::CMD_ARG, 8'h00, 32'hFFFF_FFFF, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // eight-digit hex
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_X, '0, 1'b1);
    send_item(fsnp_pkg::CMD_ARG, 8'h00, 32'hFFFF_FFFF, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // character, low byte
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_C, '0, 1'b1);
    send_item(fsnp_pkg::CMD_ARG, 8'h00, 32'h1234_5641, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // string, top-bit byte
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_S, '0, 1'b1);
    send_item(fsnp_pkg::CMD_STR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(fsnp_pkg::CMD_STR, fsnp_pkg::CH_NUL, '0, 1'b1);
    send_item(fsnp_pkg::CMD_ARG, 8'h00, 32'h8000_0001, 1'b1);     // stray argument
    send_item(fsnp_pkg::CMD_STR, 8'h7F, '0, 1'b1);                // string byte outside
    send_item(fsnp_pkg::CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b1);    // unused command code
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // unknown conversion
    send_item(fsnp_pkg::CMD_FMT, 8'h71, '0, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // decimal abandoned
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_D, '0, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, 8'h5A, '0, 1'b1);
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, '0, 1'b1);  // percent before end
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_NUL, '0, 1'b1);
  endtask

  // One message: mostly well-formed pieces with random content, some noise and
  // broken conversions, closed by a zero format byte.
  task automatic send_message();
    int unsigned pieces;
    int unsigned len;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(fsnp_pkg::CMD_FMT, pick_plain(), $urandom(), 1'b1);
        3: begin
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
        end
        4, 5, 6: begin
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
          send_item(fsnp_pkg::CMD_FMT, pick_numeric_conv(), $urandom(), 1'b1);
          send_item(fsnp_pkg::CMD_ARG, 8'($urandom()), pick_arg(), 1'b1);
        end
        7: begin
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_S, $urandom(), 1'b1);
          len = $urandom_range(0, 5);
          repeat (len) send_item(fsnp_pkg::CMD_STR, pick_byte(), $urandom(), 1'b1);
          send_item(fsnp_pkg::CMD_STR, fsnp_pkg::CH_NUL, $urandom(), 1'b1);
        end
        8: begin
          // Noise the block ignores: stray argument, stray string byte, unused code.
          case ($urandom_range(0, 2))
            0:       send_item(fsnp_pkg::CMD_ARG, 8'($urandom()), $urandom(), 1'b0);
            1:       send_item(fsnp_pkg::CMD_STR, 8'($urandom()), $urandom(), 1'b0);
            default: send_item(fsnp_pkg::CMD_NONE, 8'($urandom()), $urandom(), 1'b0);
          endcase
        end
        default: begin
          // Broken sequences.
          send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
          case ($urandom_range(0, 3))
            0: send_item(fsnp_pkg::CMD_FMT, pick_unknown_conv(), $urandom(), 1'b1);
            1: begin
              send_item(fsnp_pkg::CMD_FMT, pick_numeric_conv(), $urandom(), 1'b1);
              send_item(fsnp_pkg::CMD_FMT, pick_byte(), $urandom(), 1'b1);
            end
            2: begin
              send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_S, $urandom(), 1'b1);
              len = $urandom_range(0, 3);
              repeat (len) send_item(fsnp_pkg::CMD_STR, pick_byte(), $urandom(), 1'b1);
              send_item(fsnp_pkg::CMD_FMT, pick_byte(), $urandom(), 1'b1);
            end
            default: begin
              send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_LOW_S, $urandom(), 1'b1);
              send_item(fsnp_pkg::CMD_ARG, 8'($urandom()), $urandom(), 1'b1);
              send_item(fsnp_pkg::CMD_STR, pick_byte(), $urandom(), 1'b1);
              send_item(fsnp_pkg::CMD_STR, fsnp_pkg::CH_NUL, $urandom(), 1'b1);
            end
          endcase
        end
      endcase
    end
    // Close the message, now and then through a dangling percent.
    if ($urandom_range(0, 7) == 0) begin
      send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_PERCENT, $urandom(), 1'b1);
    end
    send_item(fsnp_pkg::CMD_FMT, fsnp_pkg::CH_NUL, $urandom(), 1'b1);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= fsnp_pkg::CMD_FMT;
    char_byte_i <= '0;
    arg_word_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items run with the destination at its reset value.
    run_directed();
    fed   = 0;
    phase = 0;

    // Random phases: drain, change the destination, toggle idling, then feed.
    while (fed < RANDOM_ITEMS) begin
      stop_sending();
      settle(SETTLE_CYCLES);
      set_destination(1'(phase % 2));
      idle_on = (phase % 3 != 2);
      target  = fed + PHASE_ITEMS;
      while (fed < target) begin
        // Now and then hold off until the block has printed everything.
        if ($urandom_range(0, 9) == 0) begin
          stop_sending();
          settle(0);
        end
        send_message();
      end
      phase++;
    end

    stop_sending();
    settle(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: stall at random, hold off for a long stretch twice so the
  // block backs up into its input, and check every accepted result.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (sb.checked == 100 || sb.checked == 400) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result('{ch: out_char_o, chv: char_valid_o, route: route_o, last: last_o,
                        done: done_res_o, total: total_length_o});
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
